>>> hdl/space_saving_heavy_hitters_assert.svh
// Assertion macros used by the checker file sshh_checker.sv.
`ifndef SPACE_SAVING_HEAVY_HITTERS_ASSERT_SVH
`define SPACE_SAVING_HEAVY_HITTERS_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SSHH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SSHH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/sshh_pkg.sv
// ----------------------------------------------------------------------------
// sshh_pkg
// Types and constants of the Space-Saving heavy-hitter table.
// ----------------------------------------------------------------------------
`default_nettype none
package sshh_pkg;
    localparam int SLOTS_DEF    = 64;
    localparam int KEY_BITS_DEF = 32;
    localparam int CNT_BITS     = 32;

    typedef enum logic {OP_INSERT = 1'b0, OP_LOOKUP = 1'b1} op_t;

    typedef struct packed {
        logic        opcode;
        logic [31:0] key;
    } req_t;

    typedef struct packed {
        logic        evicted;
        logic [31:0] evicted_key;
        logic [31:0] evicted_count;
        logic [31:0] key_count;
    } rsp_t;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

    // Scan token type; the ring cells do not use it, they pass key and count.
    typedef struct packed {
        logic                found;
        logic                have_min;
        logic [CNT_BITS-1:0] min_cnt;
    } tok_t;
endpackage
`default_nettype wire

>>> hdl/sshh_cell.sv
// ----------------------------------------------------------------------------
// sshh_cell
// One slot of the table; key/count rotate one cell per cycle while shift is high.
// ----------------------------------------------------------------------------
`default_nettype none
module sshh_cell
    import sshh_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
)(
    input  wire logic                clk,
    input  wire logic                shift,
    input  wire logic [KEY_BITS-1:0] key_in,
    input  wire logic [CNT_BITS-1:0] cnt_in,
    output logic      [KEY_BITS-1:0] key_out,
    output logic      [CNT_BITS-1:0] cnt_out
);
    logic [KEY_BITS-1:0] key_reg;
    logic [CNT_BITS-1:0] cnt_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg <= key_in;
            cnt_reg <= cnt_in;
        end
    end

    assign key_out = key_reg;
    assign cnt_out = cnt_reg;
endmodule
`default_nettype wire

>>> hdl/space_saving_heavy_hitters.sv
// ----------------------------------------------------------------------------
// space_saving_heavy_hitters
// Space-Saving frequent-item table built as a rotating ring of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with req (opcode, key) while busy is low; the transaction is
//   taken on that edge. The ring of SLOTS cells rotates once around, one
//   slot per cycle past the head cell, which compares the key, tracks the
//   lowest count (first slot wins ties) and applies the update as the slot
//   passes. After the full turn a second turn rewrites the chosen minimum
//   slot on an eviction. The result is registered as the last turn ends;
//   busy drops in the cycle after done, and a new transaction is taken
//   only once busy is low again. All slots stream through the single head
//   comparator, so only one transaction is in flight at a time.
//   The result shows on rsp with done high for one cycle; the receiver
//   cannot stall. Reset empties the table (fill count to zero); slot
//   contents are not cleared, only occupied slots are ever read.
// ----------------------------------------------------------------------------
`default_nettype none
module space_saving_heavy_hitters
    import sshh_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire req_t req,
    output logic      busy,
    output logic      done,
    output rsp_t      rsp
);
    localparam int IW = $clog2(SLOTS + 1);
    localparam logic [CNT_BITS-1:0] CMAX = '1;

    state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, used_reg, min_idx_reg;
    logic pass2_reg, op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [CNT_BITS-1:0] min_cnt_reg, kc_reg;
    logic hit_reg;
    logic [KEY_BITS-1:0] evk_reg;
    rsp_t rsp_reg;

    logic [KEY_BITS-1:0] ck [SLOTS];
    logic [CNT_BITS-1:0] cc [SLOTS];
    logic [KEY_BITS-1:0] hk;
    logic [CNT_BITS-1:0] hc;
    logic shift, occ, match;
    logic fill, upd, ev_slot;
    logic [KEY_BITS-1:0] evk_now;
    logic [CNT_BITS-1:0] kc_now;

    // head of ring is cell SLOTS-1; its output feeds back into cell 0
    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            sshh_cell #(.KEY_BITS(KEY_BITS)) u_cell (
                .clk(clk), .shift(shift),
                .key_in(g == 0 ? hk : ck[(g == 0) ? 0 : g-1]),
                .cnt_in(g == 0 ? hc : cc[(g == 0) ? 0 : g-1]),
                .key_out(ck[g]), .cnt_out(cc[g]));
        end
    endgenerate

    assign shift = (state_reg == ST_SCAN);
    assign occ   = idx_reg < used_reg;
    assign match = occ && (ck[SLOTS-1] == key_reg);
    // slot idx_reg sits at the head; ring order keeps slot numbers aligned
    assign fill    = !pass2_reg && !occ && !hit_reg && op_reg == OP_INSERT
                     && idx_reg == used_reg;
    assign ev_slot = pass2_reg && idx_reg == min_idx_reg;
    assign upd     = ev_slot || (!pass2_reg && (match || fill));
    // head values of the current cycle, for a slot updated on the last step
    assign kc_now  = upd ? hc : kc_reg;
    assign evk_now = ev_slot ? ck[SLOTS-1] : evk_reg;

    always_comb
    begin
        hk = ck[SLOTS-1];
        hc = cc[SLOTS-1];
        if (!pass2_reg)
        begin
            if (match && op_reg == OP_INSERT)
                hc = (cc[SLOTS-1] == CMAX) ? CMAX : cc[SLOTS-1] + 1'b1;
            else if (fill)
            begin
                hk = key_reg;
                hc = CNT_BITS'(1);
            end
        end
        else if (idx_reg == min_idx_reg)
        begin
            hk = key_reg;
            hc = (min_cnt_reg == CMAX) ? CMAX : min_cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_SCAN;
            ST_SCAN:
                if (idx_reg == IW'(SLOTS - 1))
                begin
                    if (pass2_reg || hit_reg || match || op_reg == OP_LOOKUP
                        || used_reg != IW'(SLOTS))
                        state_next = ST_DONE;
                end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            idx_reg   <= '0;
            pass2_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && start)
            begin
                idx_reg   <= '0;
                pass2_reg <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                if (idx_reg == IW'(SLOTS - 1))
                begin
                    idx_reg <= '0;
                    if (!pass2_reg && state_next == ST_SCAN) pass2_reg <= 1'b1;
                    if (!pass2_reg && !hit_reg && !match && op_reg == OP_INSERT
                        && used_reg != IW'(SLOTS))
                        used_reg <= used_reg + 1'b1;
                end
                else
                    idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            op_reg      <= req.opcode;
            key_reg     <= KEY_BITS'(req.key);
            hit_reg     <= 1'b0;
            kc_reg      <= '0;
            min_idx_reg <= '0;
            min_cnt_reg <= '1;
        end
        else if (state_reg == ST_SCAN && !pass2_reg)
        begin
            if (match)
            begin
                hit_reg <= 1'b1;
                kc_reg  <= hc;
            end
            else if (fill)
                kc_reg <= CNT_BITS'(1);
            if (occ && (idx_reg == '0 || cc[SLOTS-1] < min_cnt_reg))
            begin
                min_idx_reg <= idx_reg;
                min_cnt_reg <= cc[SLOTS-1];
            end
        end
        else if (state_reg == ST_SCAN && idx_reg == min_idx_reg)
        begin
            evk_reg <= ck[SLOTS-1];
            kc_reg  <= hc;
        end
        if (state_reg == ST_SCAN && state_next == ST_DONE)
        begin
            rsp_reg.evicted       <= pass2_reg;
            rsp_reg.evicted_key   <= pass2_reg ? 32'(evk_now) : '0;
            rsp_reg.evicted_count <= pass2_reg ? min_cnt_reg : '0;
            rsp_reg.key_count     <= kc_now;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);
    assign rsp  = rsp_reg;
endmodule
`default_nettype wire

>>> hdl/sshh_checker.sv
// ----------------------------------------------------------------------------
// sshh_checker
// Port-level checks of the heavy-hitter table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "space_saving_heavy_hitters_assert.svh"
module sshh_checker
    import sshh_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire rsp_t rsp
);
    `SSHH_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `SSHH_ASSERT_IMP(a_done_busy, clk, rst_n, done, busy)
    `SSHH_ASSERT_NXT(a_done_free, clk, rst_n, done, !busy)
    `SSHH_ASSERT_IMP(a_ev_zero, clk, rst_n, done && !rsp.evicted,
        rsp.evicted_key == '0 && rsp.evicted_count == '0)
    `SSHH_ASSERT_IMP(a_ev_kc, clk, rst_n, done && rsp.evicted, rsp.key_count != '0)
endmodule

bind space_saving_heavy_hitters sshh_checker u_sshh_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .rsp(rsp));
`default_nettype wire

>>> tb/sv/space_saving_heavy_hitters_tb.sv
// ----------------------------------------------------------------------------
// space_saving_heavy_hitters_tb
// Self-checking bench for the Space-Saving table: directed inserts and
// lookups (fill, eviction with ties), then random traffic drawn mostly from a
// small key pool; every result is checked against an in-bench table model.
// ----------------------------------------------------------------------------
`default_nettype none
module space_saving_heavy_hitters_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sshh_pkg::*;

    localparam int NSLOT = 64;
    localparam logic [31:0] CNT_SAT = 32'hFFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    space_saving_heavy_hitters u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .req(req),
        .busy(busy), .done(done), .rsp(rsp)
    );

    always #4 clk = ~clk;

    // table model
    logic [31:0] tbl_key [NSLOT];
    logic [31:0] tbl_cnt [NSLOT];
    int          tbl_used = 0;

    req_t pending_txn[$];
    rsp_t expected_rsp[$];
    int   send_idle_pct = 0;
    int   errors = 0;

    function automatic logic [31:0] sat_inc(logic [31:0] c);
        return (c == CNT_SAT) ? c : c + 32'd1;
    endfunction

    function automatic rsp_t table_update(req_t t);
        rsp_t r;
        int hit, m;
        r = '0;
        hit = -1;
        for (int i = 0; i < tbl_used; i++)
            if (hit < 0 && tbl_key[i] == t.key) hit = i;
        if (t.opcode == OP_LOOKUP) begin
            if (hit >= 0) r.key_count = tbl_cnt[hit];
        end else if (hit >= 0) begin
            tbl_cnt[hit] = sat_inc(tbl_cnt[hit]);
            r.key_count = tbl_cnt[hit];
        end else if (tbl_used < NSLOT) begin
            tbl_key[tbl_used] = t.key;
            tbl_cnt[tbl_used] = 32'd1;
            tbl_used++;
            r.key_count = 32'd1;
        end else begin
            m = 0;
            for (int i = 1; i < NSLOT; i++)
                if (tbl_cnt[i] < tbl_cnt[m]) m = i;
            r.evicted = 1'b1;
            r.evicted_key = tbl_key[m];
            r.evicted_count = tbl_cnt[m];
            tbl_key[m] = t.key;
            tbl_cnt[m] = sat_inc(tbl_cnt[m]);
            r.key_count = tbl_cnt[m];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) begin
                expected_rsp.insert(expected_rsp.size(), table_update(req));
            end
            if (start && busy) begin
                // hold current transaction
            end else if (pending_txn.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                start <= 1'b1;
                req <= pending_txn.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        rsp_t e;
        if (rst_n && done) begin
            if (expected_rsp.size() == 0) begin
                report_mismatch("result with no transaction outstanding", 32'd1, 32'd0);
            end else begin
                e = expected_rsp.pop_front();
                if (rsp.evicted !== e.evicted)
                    report_mismatch("evicted", {31'd0, rsp.evicted}, {31'd0, e.evicted});
                if (rsp.evicted_key !== e.evicted_key)
                    report_mismatch("evicted_key", rsp.evicted_key, e.evicted_key);
                if (rsp.evicted_count !== e.evicted_count)
                    report_mismatch("evicted_count", rsp.evicted_count, e.evicted_count);
                if (rsp.key_count !== e.key_count)
                    report_mismatch("key_count", rsp.key_count, e.key_count);
            end
        end
    end

    function automatic req_t mk(op_t op, logic [31:0] k);
        req_t t;
        t.opcode = op;
        t.key = k;
        return t;
    endfunction

    function automatic void add_txn(req_t t);
        pending_txn.insert(pending_txn.size(), t);
    endfunction

    task automatic drain();
        while (pending_txn.size() > 0 || start || expected_rsp.size() > 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 75) return 32'h1000 + $urandom_range(79);   // hot pool, forces evictions
        if (sel < 85) return 32'hFFFF_FF00 + $urandom_range(7);
        return $urandom();
    endfunction

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, miss, fill, tie eviction
        add_txn(mk(OP_LOOKUP, 32'h0));
        add_txn(mk(OP_INSERT, 32'h0));
        add_txn(mk(OP_INSERT, 32'hFFFF_FFFF));
        add_txn(mk(OP_INSERT, 32'h0));
        add_txn(mk(OP_LOOKUP, 32'h0));
        add_txn(mk(OP_LOOKUP, 32'hFFFF_FFFF));
        add_txn(mk(OP_LOOKUP, 32'h5555_AAAA));
        for (int i = 0; i < 62; i++)
            add_txn(mk(OP_INSERT, 32'hA000_0000 + i));
        add_txn(mk(OP_INSERT, 32'hAAAA_5555));  // evicts lowest slot of ties
        add_txn(mk(OP_INSERT, 32'h5555_AAAA));
        add_txn(mk(OP_LOOKUP, 32'hAAAA_5555));
        drain();

        send_idle_pct = 11;
        for (int i = 0; i < 340; i++)
            add_txn(mk(($urandom_range(3) == 0) ? OP_LOOKUP : OP_INSERT, rand_key()));
        drain();
        repeat (200) @(posedge clk);   // hold-off with nothing outstanding

        send_idle_pct = 80;
        for (int i = 0; i < 340; i++)
            add_txn(mk(($urandom_range(3) == 0) ? OP_LOOKUP : OP_INSERT, rand_key()));
        drain();

        send_idle_pct = 0;
        for (int i = 0; i < 340; i++)
            add_txn(mk(($urandom_range(3) == 0) ? OP_LOOKUP : OP_INSERT, rand_key()));
        drain();
        repeat (300) @(posedge clk);

        if (errors == 0 && expected_rsp.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #8ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
